// ===== src/gas_air_quality_index_tracker_unit_macros.svh =====
// Assertion macros for the gas air quality index tracker.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef GAS_AIR_QUALITY_INDEX_TRACKER_UNIT_MACROS_SVH
`define GAS_AIR_QUALITY_INDEX_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GAQI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gaqi check failed");
`define GAQI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gaqi check failed");
`else
`define GAQI_ASSERT(lbl, prop)
`define GAQI_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== src/gaqi_pkg.sv =====
// Package for the gas air quality index tracker: fixed-point constants,
// register codes and the divider request type. No dependencies.
`timescale 1ns / 1ps
package gaqi_pkg;

	localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
	localparam logic [29:0] LN2_Q30     = 30'd744261118;
	localparam logic [7:0]  MAGNUS_NUM  = 8'd141;
	localparam logic signed [26:0] MAGNUS_B_Q16 = 27'sd15927869;
	localparam logic signed [26:0] KELVIN_Q16   = 27'sd17901158;
	localparam logic [16:0] SVD_C_Q16   = 17'd86750;
	localparam logic [14:0] IAQ_FULL    = 15'd32000;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic signed [23:0] EXP_HI = 24'sd524288;
	localparam logic signed [23:0] EXP_LO = -24'sd2621440;
	localparam logic [39:0] COMP_MAX    = 40'hFF_FFFF_FFFF;

	localparam logic [3:0] CFG_HUMIDITY = 4'd0;
	localparam logic [3:0] CFG_BURN_IN  = 4'd1;
	localparam logic [3:0] CFG_REFRESH  = 4'd2;
	localparam logic [3:0] CFG_RING_LEN = 4'd3;

	localparam logic [15:0] RST_HUMIDITY = 16'd13550;
	localparam logic [15:0] RST_BURN_IN  = 16'd300;
	localparam logic [15:0] RST_REFRESH  = 16'd3600;
	localparam logic [7:0]  RST_RING_LEN = 8'd100;

	typedef struct packed {
		logic        start;
		logic [6:0]  nbits;
		logic [63:0] num;
		logic [39:0] rem0;
		logic [39:0] den;
	} div_req_t;

endpackage

// ===== src/gaqi_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
// Depends on nothing.
`timescale 1ns / 1ps
module gaqi_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);
	always_ff @(posedge clk) begin
		p <= 64'(a) * 64'(b);
	end
endmodule

// ===== src/gaqi_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on gaqi_pkg for the request type.
`timescale 1ns / 1ps
module gaqi_div (
	input  logic                clk,
	input  logic                arst_n,
	input  gaqi_pkg::div_req_t  req,
	output logic                done,
	output logic [63:0]         quot
);
	import gaqi_pkg::*;

	logic [6:0]  cnt_q;
	logic        done_q;
	logic [39:0] rem_q;
	logic [39:0] den_q;
	logic [63:0] quo_q;
	logic [40:0] rem_sh;
	logic        ge;
	logic [40:0] rem_sub;

	assign rem_sh  = {rem_q, quo_q[63]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.nbits;
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == 7'd1;
			if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			den_q <= req.den;
			quo_q <= req.num << (7'd64 - req.nbits);
		end else if (cnt_q != 7'd0) begin
			rem_q <= ge ? rem_sub[39:0] : rem_sh[39:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

// ===== src/gas_air_quality_index_tracker_unit.sv =====
// Channel   | Signals                                   | Direction
// in        | in_valid/in_ready, temperature, gas_resistance | in
// out       | out_valid/out_ready, air_quality, index_valid  | out
// cfg       | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
// An item makes up to 24 divisions on the shared divider, which yields one quotient bit per
// cycle, and a ring update also sums every ring entry in use (up to 128 with a full ring).
// in_ready and cfg_ready are high only in idle; a finished result waits in the output
// register, and an untaken result holds the sequencer in its last state.
// arst_n clears control state and restores register defaults; ring entries stay
// undefined until written and are read only after they are written.
// Top level; depends on gaqi_pkg, gaqi_mul, gaqi_div and the macros header.
`timescale 1ns / 1ps
`include "gas_air_quality_index_tracker_unit_macros.svh"
module gas_air_quality_index_tracker_unit #(
	parameter int RING_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] temperature,
	input  logic [31:0]        gas_resistance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [14:0]        air_quality,
	output logic               index_valid,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import gaqi_pkg::*;

	localparam int PW   = $clog2(RING_DEPTH);
	localparam int LW   = $clog2(RING_DEPTH + 1);
	localparam int CW   = (LW > 8) ? LW : 8;
	localparam int SUMW = 40 + LW;

	typedef enum logic [29:0] {
		S_IDLE      = 30'h0000_0001,
		S_MAG       = 30'h0000_0002,
		S_A_GO      = 30'h0000_0004,
		S_A_WAIT    = 30'h0000_0008,
		S_EX_X      = 30'h0000_0010,
		S_EX_F      = 30'h0000_0020,
		S_EX_Z      = 30'h0000_0040,
		S_EX_TM     = 30'h0000_0080,
		S_EX_TGO    = 30'h0000_0100,
		S_EX_TWAIT  = 30'h0000_0200,
		S_EX_SH     = 30'h0000_0400,
		S_SV_LO     = 30'h0000_0800,
		S_SV_HI     = 30'h0000_1000,
		S_SV_GO     = 30'h0000_2000,
		S_SV_WAIT   = 30'h0000_4000,
		S_HF_MUL    = 30'h0000_8000,
		S_E2        = 30'h0001_0000,
		S_CP_LO     = 30'h0002_0000,
		S_CP_HI     = 30'h0004_0000,
		S_CP_SAT    = 30'h0008_0000,
		S_DECIDE    = 30'h0010_0000,
		S_SUM       = 30'h0020_0000,
		S_MEAN_GO   = 30'h0040_0000,
		S_MEAN_WAIT = 30'h0080_0000,
		S_IDX       = 30'h0100_0000,
		S_IDX_WAIT  = 30'h0200_0000,
		S_SQ        = 30'h0400_0000,
		S_SCALE     = 30'h0800_0000,
		S_FIN       = 30'h1000_0000,
		S_OUT       = 30'h2000_0000
	} state_t;

	state_t state_q;

	// configuration and tracker state
	logic [15:0] humidity_q, burn_cfg_q, refresh_q;
	logic [7:0]  ring_len_q;
	logic [15:0] burn_left_q, period_q;
	logic [39:0] ceil_q;
	logic [PW-1:0] wp_q;
	logic        filled_q;
	logic        out_valid_q, index_valid_q;
	logic [14:0] air_quality_q;

	// datapath
	logic signed [15:0] t_q;
	logic [31:0] gas_q;
	logic        pass_q;
	logic signed [23:0] exp_x_q;
	logic        x_neg_q;
	logic signed [9:0] k_q;
	logic [29:0] z_q;
	logic [30:0] term_q;
	logic [31:0] exp_sum_q;
	logic [3:0]  n_q;
	logic [42:0] exp_g_q;
	logic [63:0] prod_lo_q;
	logic [31:0] svd_q;
	logic [39:0] comp_q;
	logic [LW-1:0] cnt_q, sum_idx_q;
	logic        acc_v_q;
	logic [SUMW-1:0] ring_sum_q;
	logic [29:0] r_q;
	logic [14:0] res_aq_q;
	logic        res_iv_q;

	logic [39:0] ring_mem [RING_DEPTH];
	logic [39:0] rd_q;
	logic        ring_we;
	logic [PW-1:0] ring_wa;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	div_req_t    div_req;
	logic        div_done;
	logic [63:0] div_quot;

	gaqi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
	gaqi_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .done(div_done),
		.quot(div_quot));

	// effective ring length
	logic [CW-1:0] rl_ext, len_c;
	logic [LW-1:0] len_eff;
	assign rl_ext  = CW'(ring_len_q);
	assign len_c   = (rl_ext < CW'(2)) ? CW'(2) :
		((rl_ext > CW'(RING_DEPTH)) ? CW'(RING_DEPTH) : rl_ext);
	assign len_eff = len_c[LW-1:0];

	// temperature derived terms
	logic signed [26:0] t_sc, t_neg, d1_full, d2_full;
	logic [16:0] t_mag;
	assign t_sc    = {{11{t_q[15]}}, t_q};
	assign t_neg   = -t_sc;
	assign t_mag   = t_q[15] ? t_neg[16:0] : t_sc[16:0];
	assign d1_full = (t_sc <<< 8) + MAGNUS_B_Q16;
	assign d2_full = (t_sc <<< 8) + KELVIN_Q16;

	// exp argument handling
	logic signed [23:0] xc, xc_neg;
	logic [63:0] p_ceil;
	logic [24:0] y_mag;
	logic signed [25:0] y_s;
	logic signed [9:0] k_neg;
	logic [42:0] g_shift;
	assign xc     = (exp_x_q < EXP_LO) ? EXP_LO : ((exp_x_q > EXP_HI) ? EXP_HI : exp_x_q);
	assign xc_neg = -xc;
	assign p_ceil = mul_p + 64'h3FFF_FFFF;
	assign y_mag  = x_neg_q ? p_ceil[54:30] : mul_p[54:30];
	assign y_s    = x_neg_q ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
	assign k_neg  = -k_q;
	assign g_shift = k_q[9] ? (43'(exp_sum_q) >> k_neg[5:0]) : (43'(exp_sum_q) << k_q[3:0]);

	// compensation and tracker decisions
	logic [51:0] comp_full;
	logic [15:0] period_inc;
	logic        refresh, do_write;
	logic [PW-1:0] w_pos;
	logic [LW-1:0] w_next;
	logic [19:0] e2_raw;
	logic signed [23:0] qa;
	assign comp_full  = {mul_p[43:0], 8'b0} + 52'(prod_lo_q[63:24]);
	assign period_inc = period_q + 16'd1;
	assign refresh    = period_inc >= refresh_q;
	assign do_write   = refresh || (comp_q > ceil_q);
	assign w_pos      = (LW'(wp_q) >= len_eff) ? '0 : wp_q;
	assign w_next     = LW'(w_pos) + LW'(1);
	assign e2_raw     = mul_p[47:28];
	assign qa         = $signed(div_quot[23:0]);

	assign ring_we = (state_q == S_DECIDE) &&
		(((burn_left_q != 16'd0) && (burn_left_q == 16'd1)) ||
		 ((burn_left_q == 16'd0) && do_write));
	assign ring_wa = (burn_left_q != 16'd0) ? '0 : w_pos;

	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[ring_wa] <= comp_q;
		rd_q <= ring_mem[sum_idx_q[PW-1:0]];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_req = '0;
		unique case (state_q)
			S_MAG: begin
				mul_a = 32'(t_mag);
				mul_b = 32'(MAGNUS_NUM);
			end
			S_A_GO: begin
				div_req.start = 1'b1;
				div_req.nbits = 7'd44;
				div_req.num   = {mul_p[42:0], 21'b0};
				div_req.den   = 40'(d1_full[24:0]);
			end
			S_EX_X: begin
				mul_a = 32'(xc[23] ? xc_neg : xc);
				mul_b = 32'(LOG2E_Q30);
			end
			S_EX_F: begin
				mul_a = 32'(y_s[15:0]);
				mul_b = 32'(LN2_Q30);
			end
			S_EX_TM: begin
				mul_a = 32'(term_q);
				mul_b = 32'(z_q);
			end
			S_EX_TGO: begin
				div_req.start = 1'b1;
				div_req.nbits = 7'd32;
				div_req.num   = 64'(mul_p[63:30]);
				div_req.den   = 40'(n_q);
			end
			S_SV_LO: begin
				mul_a = exp_g_q[31:0];
				mul_b = 32'(SVD_C_Q16);
			end
			S_SV_HI: begin
				mul_a = 32'(exp_g_q[42:32]);
				mul_b = 32'(SVD_C_Q16);
			end
			S_SV_GO: begin
				div_req.start = 1'b1;
				div_req.nbits = 7'd61;
				div_req.num   = {mul_p[31:0], 32'b0} + prod_lo_q;
				div_req.den   = 40'(d2_full[24:0]);
			end
			S_HF_MUL: begin
				mul_a = svd_q;
				mul_b = 32'(humidity_q);
			end
			S_CP_LO: begin
				mul_a = gas_q;
				mul_b = exp_g_q[31:0];
			end
			S_CP_HI: begin
				mul_a = gas_q;
				mul_b = 32'(exp_g_q[42:32]);
			end
			S_MEAN_GO: begin
				div_req.start = 1'b1;
				div_req.nbits = 7'(SUMW);
				div_req.num   = 64'(ring_sum_q);
				div_req.den   = 40'(cnt_q);
			end
			S_IDX: begin
				div_req.start = (ceil_q != 40'd0) && (comp_q < ceil_q);
				div_req.nbits = 7'd30;
				div_req.rem0  = comp_q;
				div_req.den   = ceil_q;
			end
			S_SQ: begin
				mul_a = 32'(r_q);
				mul_b = 32'(r_q);
			end
			S_SCALE: begin
				mul_a = 32'(IAQ_FULL);
				mul_b = 32'(ONE_Q30) - 32'(mul_p[59:30]);
			end
			default: begin
			end
		endcase
	end

	// control: sequencer, tracker state, registers, output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			humidity_q  <= RST_HUMIDITY;
			burn_cfg_q  <= RST_BURN_IN;
			refresh_q   <= RST_REFRESH;
			ring_len_q  <= RST_RING_LEN;
			burn_left_q <= RST_BURN_IN;
			period_q    <= '0;
			ceil_q      <= '0;
			wp_q        <= PW'(1);
			filled_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_OUT)) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index) inside
					CFG_HUMIDITY: humidity_q <= cfg_data;
					CFG_REFRESH:  refresh_q  <= cfg_data;
					CFG_BURN_IN, CFG_RING_LEN: begin
						if (cfg_index == CFG_BURN_IN) begin
							burn_cfg_q  <= cfg_data;
							burn_left_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
						end else begin
							ring_len_q  <= cfg_data[7:0];
							burn_left_q <= (burn_cfg_q == 16'd0) ? 16'd1 : burn_cfg_q;
						end
						period_q <= '0;
						ceil_q   <= '0;
						wp_q     <= PW'(1);
						filled_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE:      if (in_valid) state_q <= S_MAG;
				S_MAG:       state_q <= S_A_GO;
				S_A_GO:      state_q <= S_A_WAIT;
				S_A_WAIT:    if (div_done) state_q <= S_EX_X;
				S_EX_X:      state_q <= S_EX_F;
				S_EX_F:      state_q <= S_EX_Z;
				S_EX_Z:      state_q <= S_EX_TM;
				S_EX_TM:     state_q <= S_EX_TGO;
				S_EX_TGO:    state_q <= S_EX_TWAIT;
				S_EX_TWAIT:  if (div_done) state_q <= (n_q == 4'd10) ? S_EX_SH : S_EX_TM;
				S_EX_SH:     state_q <= pass_q ? S_CP_LO : S_SV_LO;
				S_SV_LO:     state_q <= S_SV_HI;
				S_SV_HI:     state_q <= S_SV_GO;
				S_SV_GO:     state_q <= S_SV_WAIT;
				S_SV_WAIT:   if (div_done) state_q <= S_HF_MUL;
				S_HF_MUL:    state_q <= S_E2;
				S_E2:        state_q <= S_EX_X;
				S_CP_LO:     state_q <= S_CP_HI;
				S_CP_HI:     state_q <= S_CP_SAT;
				S_CP_SAT:    state_q <= S_DECIDE;
				S_DECIDE: begin
					if (burn_left_q != 16'd0) begin
						burn_left_q <= burn_left_q - 16'd1;
						if (burn_left_q == 16'd1) ceil_q <= comp_q;
						state_q <= S_OUT;
					end else if (do_write) begin
						period_q <= refresh ? 16'd0 : period_inc;
						if (w_next >= len_eff) begin
							wp_q     <= '0;
							filled_q <= 1'b1;
						end else begin
							wp_q <= w_next[PW-1:0];
						end
						state_q <= S_SUM;
					end else begin
						period_q <= period_inc;
						state_q  <= S_IDX;
					end
				end
				S_SUM:       if ((sum_idx_q == cnt_q) && !acc_v_q) state_q <= S_MEAN_GO;
				S_MEAN_GO:   state_q <= S_MEAN_WAIT;
				S_MEAN_WAIT: begin
					if (div_done) begin
						ceil_q  <= div_quot[39:0];
						state_q <= S_IDX;
					end
				end
				S_IDX:       state_q <= div_req.start ? S_IDX_WAIT : S_OUT;
				S_IDX_WAIT:  if (div_done) state_q <= S_SQ;
				S_SQ:        state_q <= S_SCALE;
				S_SCALE:     state_q <= S_FIN;
				S_FIN:       state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q) inside
			S_IDLE: begin
				t_q    <= temperature;
				gas_q  <= gas_resistance;
				pass_q <= 1'b0;
			end
			S_A_WAIT: if (div_done) exp_x_q <= t_q[15] ? -qa : qa;
			S_EX_X: x_neg_q <= xc[23];
			S_EX_F: begin
				k_q       <= y_s[25:16];
				term_q    <= ONE_Q30;
				exp_sum_q <= 32'(ONE_Q30);
				n_q       <= 4'd1;
			end
			S_EX_Z: z_q <= mul_p[45:16];
			S_EX_TWAIT: begin
				if (div_done) begin
					term_q    <= div_quot[30:0];
					exp_sum_q <= exp_sum_q + div_quot[31:0];
					n_q       <= n_q + 4'd1;
				end
			end
			S_EX_SH: exp_g_q <= g_shift;
			S_SV_HI, S_CP_HI: prod_lo_q <= mul_p;
			S_SV_WAIT: if (div_done) svd_q <= div_quot[31:0];
			S_E2: begin
				exp_x_q <= (e2_raw > 20'd524288) ? EXP_HI : 24'(e2_raw);
				pass_q  <= 1'b1;
			end
			S_CP_SAT: comp_q <= (comp_full > 52'(COMP_MAX)) ? COMP_MAX : comp_full[39:0];
			S_DECIDE: begin
				res_aq_q   <= '0;
				res_iv_q   <= burn_left_q == 16'd0;
				ring_sum_q <= '0;
				sum_idx_q  <= '0;
				acc_v_q    <= 1'b0;
				cnt_q      <= ((w_next >= len_eff) || filled_q) ? len_eff : w_next;
			end
			S_SUM: begin
				if (sum_idx_q < cnt_q) sum_idx_q <= sum_idx_q + LW'(1);
				acc_v_q <= sum_idx_q < cnt_q;
				if (acc_v_q) ring_sum_q <= ring_sum_q + SUMW'(rd_q);
			end
			S_IDX_WAIT: if (div_done) r_q <= div_quot[29:0];
			S_FIN: res_aq_q <= mul_p[44:30];
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					air_quality_q <= res_aq_q;
					index_valid_q <= res_iv_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = state_q == S_IDLE;
	assign cfg_ready   = state_q == S_IDLE;
	assign out_valid   = out_valid_q;
	assign air_quality = air_quality_q;
	assign index_valid = index_valid_q;

	`GAQI_ASSERT_IMP(a_div_done_in_wait, div_done, (state_q == S_A_WAIT) || (state_q == S_EX_TWAIT) || (state_q == S_SV_WAIT) || (state_q == S_MEAN_WAIT) || (state_q == S_IDX_WAIT))
	`GAQI_ASSERT(a_wp_in_range, LW'(wp_q) < len_eff)
	`GAQI_ASSERT_IMP(a_valid_after_burn, out_valid_q && index_valid_q, burn_left_q == 16'd0)
	`GAQI_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == S_OUT))
endmodule

// ===== dv/gas_air_quality_index_tracker_unit_test.sv =====
// Self-checking testbench for gas_air_quality_index_tracker_unit: predicts the
// compensated gas value, calibration ring and index for every item and checks each result.
// Depends on gaqi_pkg and the tracker RTL.
`timescale 1ns / 1ps

typedef struct {
	logic [14:0] air_quality;
	logic        index_valid;
} aqi_result_t;

class aqi_scoreboard;
	localparam longint unsigned LOG2E = 64'd1549082005;
	localparam longint unsigned LN2   = 64'd744261118;
	localparam longint unsigned ONE   = 64'd1 << 30;
	localparam longint unsigned CMAX  = (64'd1 << 40) - 64'd1;

	logic [15:0] humidity;
	logic [15:0] burn_in;
	logic [15:0] refresh;
	logic [7:0]  ring_len;

	int unsigned     burn_left;
	logic [15:0]     period;
	longint unsigned ceiling;
	longint unsigned ring [128];
	int              wr_pos;
	bit              filled;

	aqi_result_t pending [$];
	int errors;
	int n_items, n_valid, n_refills, n_results;

	function new();
		humidity = 16'd13550;
		burn_in  = 16'd300;
		refresh  = 16'd3600;
		ring_len = 8'd100;
		errors = 0;
		restart();
	endfunction

	function void restart();
		burn_left = (burn_in == 0) ? 1 : burn_in;
		period = 0;
		ceiling = 0;
		foreach (ring[i]) ring[i] = 0;
		wr_pos = 1;
		filled = 0;
	endfunction

	function void write_reg(logic [3:0] idx, logic [15:0] data);
		case (idx)
			gaqi_pkg::CFG_HUMIDITY: humidity = data;
			gaqi_pkg::CFG_BURN_IN: begin
				burn_in = data;
				restart();
			end
			gaqi_pkg::CFG_REFRESH: refresh = data;
			gaqi_pkg::CFG_RING_LEN: begin
				ring_len = data[7:0];
				restart();
			end
			default: ;
		endcase
	endfunction

	function longint unsigned exp_fix(longint x);
		longint y, k;
		longint unsigned f, z, sum, term;
		if (x < -40 * 65536) x = -40 * 65536;
		if (x > 8 * 65536) x = 8 * 65536;
		y = (x * longint'(LOG2E)) >>> 30;
		k = y >>> 16;
		f = longint'(y - k * 65536);
		z = (f * LN2) >> 16;
		sum = ONE;
		term = ONE;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * z) >> 30) / n;
			sum += term;
		end
		return (k >= 0) ? (sum << k) : (sum >> (-k));
	endfunction

	function longint unsigned compensated_gas(int t, longint unsigned gas);
		longint unsigned mag, q, e1, svd, g, comp;
		longint a, d1, d2, e2;
		d1 = longint'(t) * 256 + 15927869;
		d2 = longint'(t) * 256 + 17901158;
		mag = (t < 0) ? -t : t;
		q = ((64'd141 * mag) << 21) / longint'(d1);
		a = (t < 0) ? -longint'(q) : longint'(q);
		e1 = exp_fix(a);
		svd = (e1 * 64'd86750) / longint'(d2);
		e2 = longint'((svd * humidity) >> 28);
		g = exp_fix(e2);
		comp = ((gas * (g >> 32)) << 8) + ((gas * (g & 64'hFFFF_FFFF)) >> 24);
		return (comp > CMAX) ? CMAX : comp;
	endfunction

	function longint unsigned index_from(longint unsigned comp, longint unsigned ceil_v);
		logic [71:0] ratio;
		longint unsigned r, r2;
		if (ceil_v == 0 || comp >= ceil_v) return 0;
		ratio = {comp[41:0], 30'b0} / ceil_v;
		r = ratio[63:0];
		r2 = (r * r) >> 30;
		return (64'd32000 * (ONE - r2)) >> 30;
	endfunction

	function void note_input(logic signed [15:0] t, logic [31:0] gas);
		longint unsigned comp, sum, idx;
		int len, n;
		bit refresh_now;
		aqi_result_t res;
		n_items++;
		comp = compensated_gas(int'(t), longint'(gas));
		len = (ring_len < 2) ? 2 : ((ring_len > 128) ? 128 : ring_len);
		if (burn_left > 0) begin
			burn_left--;
			if (burn_left == 0) begin
				ring[0] = comp;
				ceiling = comp;
			end
			res.air_quality = 0;
			res.index_valid = 0;
			pending.push_back(res);
			return;
		end
		n_valid++;
		period = period + 16'd1;
		refresh_now = (period >= refresh);
		if (refresh_now || comp > ceiling) begin
			n_refills++;
			if (refresh_now) period = 0;
			if (wr_pos >= len) wr_pos = 0;
			ring[wr_pos] = comp;
			wr_pos++;
			if (wr_pos >= len) begin
				wr_pos = 0;
				filled = 1;
			end
			n = filled ? len : wr_pos;
			sum = 0;
			for (int i = 0; i < n; i++) sum += ring[i];
			ceiling = (n != 0) ? sum / n : 0;
		end
		idx = index_from(comp, ceiling);
		res.air_quality = idx[14:0];
		res.index_valid = 1;
		pending.push_back(res);
	endfunction

	function void check_result(logic [14:0] aq, logic iv);
		aqi_result_t exp_r;
		n_results++;
		if (pending.size() == 0) begin
			$display("%0t: unexpected item air_quality=%0d index_valid=%0d", $time, aq, iv);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (aq !== exp_r.air_quality) begin
			$display("%0t: air_quality expected %0d actual %0d", $time,
				exp_r.air_quality, aq);
			errors++;
		end
		if (iv !== exp_r.index_valid) begin
			$display("%0t: index_valid expected %0d actual %0d", $time,
				exp_r.index_valid, iv);
			errors++;
		end
	endfunction
endclass

module gas_air_quality_index_tracker_unit_test;
	import gaqi_pkg::*;

	localparam logic [3:0] CFG_UNUSED_A = 4'd9;
	localparam logic [3:0] CFG_UNUSED_B = 4'd15;
	localparam int CYCLE_LIMIT = 12_000_000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [15:0] temperature = 0;
	logic [31:0]        gas_resistance = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [14:0]        air_quality;
	logic               index_valid;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [3:0]         cfg_index = 0;
	logic [15:0]        cfg_data = 0;

	aqi_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	bit hold_req = 0;
	int cycles = 0;
	int unsigned gas_base;
	int temp_base;

	gas_air_quality_index_tracker_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.temperature(temperature), .gas_resistance(gas_resistance),
		.out_valid(out_valid), .out_ready(out_ready),
		.air_quality(air_quality), .index_valid(index_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && out_valid && out_ready)
			sb.check_result(air_quality, index_valid);
	end

	// hold off the receiver for a long stretch when asked
	always @(negedge clk) begin
		if (hold_req && hold_cycles == 0) begin
			hold_cycles = 3000;
			hold_req = 0;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic send_item(logic signed [15:0] t, logic [31:0] gas);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		temperature <= t;
		gas_resistance <= gas;
		do @(posedge clk); while (!in_ready);
		sb.note_input(t, gas);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		wait (sb.pending.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_random();
		int r;
		logic signed [15:0] t;
		logic [31:0] gas;
		r = int'($urandom_range(0, 99));
		t = 16'(temp_base + int'($urandom_range(0, 512)) - 256);
		if (r < 70) gas = gas_base - (gas_base >> 3) + $urandom_range(0, gas_base >> 2);
		else if (r < 84) gas = gas_base * 2 + $urandom_range(0, gas_base);
		else if (r < 92) begin
			gas_base = gas_base + (gas_base >> 4);
			gas = gas_base;
		end else begin
			gas = $urandom;
			t = 16'(int'($urandom_range(0, 32000)) - 10240);
		end
		send_item(t, gas);
	endtask

	task automatic random_config();
		case ($urandom_range(0, 3))
			0: write_reg(CFG_HUMIDITY, 16'd0);
			1: write_reg(CFG_HUMIDITY, 16'hFFFF);
			2: write_reg(CFG_HUMIDITY, 16'd13550);
			default: write_reg(CFG_HUMIDITY, 16'($urandom_range(0, 65535)));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(CFG_REFRESH, 16'd0);
			1: write_reg(CFG_REFRESH, 16'd1);
			2: write_reg(CFG_REFRESH, 16'hFFFF);
			default: write_reg(CFG_REFRESH, 16'($urandom_range(2, 30)));
		endcase
		case ($urandom_range(0, 5))
			0: write_reg(CFG_RING_LEN, 16'd0);
			1: write_reg(CFG_RING_LEN, 16'd1);
			2: write_reg(CFG_RING_LEN, 16'd2);
			3: write_reg(CFG_RING_LEN, 16'd128);
			4: write_reg(CFG_RING_LEN, 16'hFFFF);
			default: write_reg(CFG_RING_LEN, 16'($urandom_range(3, 12)));
		endcase
		write_reg(CFG_BURN_IN,
			($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
	endtask

	initial begin
		logic signed [15:0] t_dir [5] = '{-16'sd10240, 16'sd21760, 16'sd0, 16'sd6400, -16'sd1};
		logic [31:0] g_dir [4] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd100000};
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		for (int i = 0; i < 4; i++) send_item(t_dir[i], g_dir[i]);
		drain();
		write_reg(CFG_BURN_IN, 16'hFFFF);
		send_item(16'sd2560, 32'd50000);
		send_item(16'sd2560, 32'd50000);
		drain();
		write_reg(CFG_HUMIDITY, 16'hFFFF);
		write_reg(CFG_REFRESH, 16'd0);
		write_reg(CFG_RING_LEN, 16'd0);
		write_reg(CFG_BURN_IN, 16'd0);
		write_reg(CFG_UNUSED_A, 16'hFFFF);
		write_reg(CFG_UNUSED_B, 16'h0000);
		for (int i = 0; i < 5; i++) send_item(t_dir[i], g_dir[i % 4]);
		for (int i = 0; i < 5; i++) send_item(t_dir[4 - i], g_dir[(i + 2) % 4]);
		drain();
		write_reg(CFG_HUMIDITY, 16'd0);
		write_reg(CFG_RING_LEN, 16'd128);
		write_reg(CFG_BURN_IN, 16'd1);
		for (int i = 0; i < 4; i++) send_item(t_dir[i], g_dir[3 - i]);
		drain();

		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			random_config();
			gas_base = $urandom_range(20000, 2000000);
			temp_base = int'($urandom_range(0, 30000)) - 9000;
			if (p == 2) hold_req = 1;
			repeat (107) send_random();
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Covered %0d items (%0d past burn-in, %0d ring updates), %0d results checked,",
			sb.n_items, sb.n_valid, sb.n_refills, sb.n_results);
		$display("over 12 random phases with mixed idling and a long receiver hold-off.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
